[design/packed_points_deltas_parser_top_assert.svh]
// Assertion macros used by the parser top level.
`ifndef PACKED_POINTS_DELTAS_PARSER_TOP_ASSERT_SVH
`define PACKED_POINTS_DELTAS_PARSER_TOP_ASSERT_SVH

// Plain property, checked on every rising clock edge outside reset.
`define PPDP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define PPDP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/ppdp_pkg.sv]
`default_nettype none

package ppdp_pkg;

   localparam logic [1:0] KIND_SHARED  = 2'd0;
   localparam logic [1:0] KIND_PLAIN   = 2'd1;
   localparam logic [1:0] KIND_PRIVATE = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   localparam logic [7:0] MASK_TOP_BIT  = 8'h80;
   localparam logic [7:0] MASK_LOW7     = 8'h7F;
   localparam logic [7:0] MASK_WORD_RUN = 8'h40;
   localparam logic [7:0] MASK_LOW6     = 8'h3F;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_COUNT  = 3'd1,
      PH_COUNT2 = 3'd2,
      PH_PRUN   = 3'd3,
      PH_PVAL   = 3'd4,
      PH_DCTRL  = 3'd5,
      PH_DVAL   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      TK_COUNT = 3'd0,
      TK_PRUN  = 3'd1,
      TK_POINT = 3'd2,
      TK_DCTRL = 3'd3,
      TK_DELTA = 3'd4,
      TK_ZERO  = 3'd5,
      TK_ERROR = 3'd6
   } token_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        section_start;
      logic [1:0]  section_kind;
      logic [15:0] section_size;
   } req_type;

   typedef struct packed {
      token_type   token;
      logic [15:0] value;
      logic        value_is_word;
      logic        section_end;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [14:0] points_left;
      logic [6:0]  run_left;
      logic        run_words;
      logic [15:0] bytes_left;
      logic [7:0]  high_byte;
      logic        word_half;
      logic        budgeted;
   } state_type;

   localparam state_type STATE_IDLE = '{
      phase:       PH_IDLE,
      points_left: 15'd0,
      run_left:    7'd0,
      run_words:   1'b0,
      bytes_left:  16'd0,
      high_byte:   8'd0,
      word_half:   1'b0,
      budgeted:    1'b0
   };

endpackage

`default_nettype wire

[design/ppdp_in_reg.sv]
`default_nettype none

module ppdp_in_reg
   import ppdp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_in,
   input  wire logic    advance,
   output logic         s1_valid,
   output req_type      s1_req
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_req   = data_ff;

endmodule

`default_nettype wire

[design/ppdp_core.sv]
`default_nettype none

module ppdp_core
   import ppdp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type req,
   output logic         have,
   output rsp_type      result
);

   state_type st_ff;
   state_type st_in;

   always_comb begin
      state_type   cur;
      logic [7:0]  b;
      logic        done;
      logic        pdone;
      token_type   tok;
      logic [15:0] val;
      logic        word;
      logic        fin;

      cur   = st_ff;
      b     = req.data_byte;
      done  = 1'b0;
      pdone = 1'b0;
      have  = 1'b0;
      tok   = TK_COUNT;
      val   = 16'd0;
      word  = 1'b0;
      fin   = 1'b0;

      if (req.section_start) begin
         cur = STATE_IDLE;
         if (req.section_kind == KIND_INVALID) begin
            have = 1'b1;
            tok  = TK_ERROR;
            val  = {8'h00, b};
            fin  = 1'b1;
            done = 1'b1;
         end else begin
            cur.budgeted   = (req.section_kind != KIND_SHARED);
            cur.bytes_left = cur.budgeted ? req.section_size : 16'd0;
            cur.phase      = (req.section_kind == KIND_PLAIN) ? PH_DCTRL : PH_COUNT;
         end
      end else if (cur.phase == PH_IDLE) begin
         done = 1'b1;
      end

      if (!done && cur.budgeted) begin
         if (cur.bytes_left == 16'd0) begin
            cur  = STATE_IDLE;
            have = 1'b1;
            tok  = TK_ERROR;
            val  = {8'h00, b};
            fin  = 1'b1;
            done = 1'b1;
         end else begin
            cur.bytes_left = cur.bytes_left - 16'd1;
         end
      end

      if (!done) begin
         unique case (cur.phase)
            PH_COUNT: begin
               if ((b & MASK_TOP_BIT) != 8'h00) begin
                  cur.high_byte = b & MASK_LOW7;
                  cur.phase     = PH_COUNT2;
               end else begin
                  tok  = TK_COUNT;
                  val  = {8'h00, b};
                  have = 1'b1;
                  cur.points_left = {7'd0, b};
                  if (b == 8'h00) begin
                     pdone = 1'b1;
                  end else begin
                     cur.phase = PH_PRUN;
                  end
               end
            end
            PH_COUNT2: begin
               val  = {cur.high_byte, b};
               tok  = TK_COUNT;
               word = 1'b1;
               have = 1'b1;
               cur.points_left = val[14:0];
               cur.high_byte   = 8'h00;
               if (val[14:0] == 15'd0) begin
                  pdone = 1'b1;
               end else begin
                  cur.phase = PH_PRUN;
               end
            end
            PH_PRUN: begin
               tok  = TK_PRUN;
               val  = {8'h00, b};
               have = 1'b1;
               cur.run_left  = b[6:0];
               cur.run_words = b[7];
               cur.word_half = 1'b0;
               cur.phase     = PH_PVAL;
            end
            PH_PVAL, PH_DVAL: begin
               if (cur.run_words && !cur.word_half) begin
                  // high byte of a word; nothing to report yet
                  cur.high_byte = b;
                  cur.word_half = 1'b1;
               end else begin
                  if (cur.run_words) begin
                     val  = {cur.high_byte, b};
                     word = 1'b1;
                     cur.word_half = 1'b0;
                     cur.high_byte = 8'h00;
                  end else begin
                     val = {8'h00, b};
                  end
                  have = 1'b1;
                  if (cur.phase == PH_PVAL) begin
                     tok = TK_POINT;
                     cur.points_left = cur.points_left - 15'd1;
                     if (cur.points_left == 15'd0) begin
                        pdone = 1'b1;
                     end else if (cur.run_left == 7'd0) begin
                        cur.phase = PH_PRUN;
                     end else begin
                        cur.run_left = cur.run_left - 7'd1;
                     end
                  end else begin
                     tok = TK_DELTA;
                     if (cur.run_left == 7'd0) begin
                        cur.phase = PH_DCTRL;
                     end else begin
                        cur.run_left = cur.run_left - 7'd1;
                     end
                  end
               end
            end
            PH_DCTRL: begin
               have = 1'b1;
               if ((b & MASK_TOP_BIT) != 8'h00) begin
                  // zero run wins over the word flag
                  tok = TK_ZERO;
                  val = {8'h00, b & MASK_LOW6} + 16'd1;
               end else begin
                  tok = TK_DCTRL;
                  val = {8'h00, b};
                  cur.run_left  = {1'b0, b[5:0]};
                  cur.run_words = ((b & MASK_WORD_RUN) != 8'h00);
                  cur.word_half = 1'b0;
                  cur.phase     = PH_DVAL;
               end
            end
            default: begin
               cur  = STATE_IDLE;
               done = 1'b1;
            end
         endcase
      end

      if (!done) begin
         if (pdone) begin
            cur.run_left  = 7'd0;
            cur.run_words = 1'b0;
            cur.word_half = 1'b0;
            if (cur.budgeted) begin
               cur.phase = PH_DCTRL;
            end else begin
               fin = 1'b1;
               cur = STATE_IDLE;
            end
         end

         // budget used up: clean end after a finished run, error otherwise
         if (cur.budgeted && cur.phase != PH_IDLE && cur.bytes_left == 16'd0) begin
            if (cur.phase == PH_DCTRL) begin
               fin = 1'b1;
            end else begin
               tok  = TK_ERROR;
               val  = {8'h00, b};
               word = 1'b0;
               fin  = 1'b1;
               have = 1'b1;
            end
            cur = STATE_IDLE;
         end
      end

      st_in                = step ? cur : st_ff;
      result.token         = tok;
      result.value         = val;
      result.value_is_word = word;
      result.section_end   = fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

[design/ppdp_out_reg.sv]
`default_nettype none

module ppdp_out_reg
   import ppdp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire logic    have,
   input  wire rsp_type result,
   output logic         free,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_out
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = have;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && have) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = data_ff;

endmodule

`default_nettype wire

[design/packed_points_deltas_parser_top.sv]
// Packed point numbers / packed deltas tokenizer.
// Request channel (req_*): one byte of a serialized section per request, with
// section_start marking the first byte and section_kind / section_size read
// on that byte. Response channel (rsp_*): at most one token per request,
// carrying token code, raw value, word flag and section_end.
// Both channels are valid/stall; a transfer happens when valid is high and
// stall is low at a rising clock edge.
// Each byte is taken into the input register, stepped through the core, and
// its token is registered in the output register, which drives rsp_valid.
// Throughput: one byte per cycle while the receiver does not stall; the
// parser state update is a loop through the core register.
// Bytes that produce no token (idle bytes, word high halves) still step
// through the core and load no token into the output register.
// Reset (synchronous, active high) drops both registered stages and returns
// the parser to idle; no section is in progress afterwards.
// When the receiver stalls, the pending token is held in the output register
// while one more byte is parked in the input register; after that req_stall
// rises until the token is taken.
`default_nettype none
`include "packed_points_deltas_parser_top_assert.svh"

module packed_points_deltas_parser_top
   import ppdp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_section_start,
   input  wire logic [1:0]  req_section_kind,
   input  wire logic [15:0] req_section_size,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_token,
   output logic [15:0]      rsp_value,
   output logic             rsp_value_is_word,
   output logic             rsp_section_end
);

   req_type req_bus;
   req_type s1_req;
   logic    s1_valid;
   logic    step;
   logic    out_free;
   logic    core_have;
   rsp_type core_result;
   rsp_type rsp_bus;

   assign req_bus.data_byte     = req_data_byte;
   assign req_bus.section_start = req_section_start;
   assign req_bus.section_kind  = req_section_kind;
   assign req_bus.section_size  = req_section_size;

   assign step = s1_valid && out_free;

   ppdp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_in    (req_bus),
      .advance   (step),
      .s1_valid  (s1_valid),
      .s1_req    (s1_req)
   );

   ppdp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (s1_req),
      .have   (core_have),
      .result (core_result)
   );

   ppdp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .have      (core_have),
      .result    (core_result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out   (rsp_bus)
   );

   assign rsp_token         = rsp_bus.token;
   assign rsp_value         = rsp_bus.value;
   assign rsp_value_is_word = rsp_bus.value_is_word;
   assign rsp_section_end   = rsp_bus.section_end;

   `PPDP_ASSERT(a_no_false_stall, (s1_valid && !rsp_stall) |-> !req_stall,
                "input stalled with free output")
   `PPDP_ASSERT_NEXT(a_bad_kind_error,
                     step && s1_req.section_start && s1_req.section_kind == KIND_INVALID,
                     rsp_valid && rsp_token == TK_ERROR && rsp_section_end,
                     "bad kind gave no error")
   `PPDP_ASSERT_NEXT(a_silent_byte, step && !core_have, !rsp_valid,
                     "token shown for a silent byte")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import ppdp_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEM_TARGET = 1350;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_section_start = 1'b0;
   logic [1:0]  req_section_kind = KIND_SHARED;
   logic [15:0] req_section_size = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_token;
   logic [15:0] rsp_value;
   logic        rsp_value_is_word;
   logic        rsp_section_end;

   packed_points_deltas_parser_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_section_start (req_section_start),
      .req_section_kind  (req_section_kind),
      .req_section_size  (req_section_size),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token         (rsp_token),
      .rsp_value         (rsp_value),
      .rsp_value_is_word (rsp_value_is_word),
      .rsp_section_end   (rsp_section_end)
   );

   typedef struct {
      phase_type   ph;
      logic [14:0] pts_left;
      logic [6:0]  run_left;
      logic        run_words;
      logic [16:0] budget;
      logic [7:0]  hi;
      logic        half;
      logic        budgeted;
   } parse_state_type;

   parse_state_type parser;
   req_type      byte_feed[$];
   rsp_type      tokens_due[$];
   logic [7:0]   sec_bytes[$];

   int fail_count = 0;
   int reqs_taken = 0;
   int tokens_taken = 0;
   int sections_built = 0;
   int tok_hits[7];
   int quiet_cycles = 0;

   // sender and receiver pacing
   int      burst_left = 0;
   int      gap_left = 0;
   req_type next_req;
   int      seg_left = 0;
   int      stall_mode = 0;
   int      hold_left = 0;
   int      holds_done = 0;
   int      cyc = 0;

   function automatic void parser_to_idle();
      parser.ph        = PH_IDLE;
      parser.pts_left  = '0;
      parser.run_left  = '0;
      parser.run_words = 1'b0;
      parser.budget    = '0;
      parser.hi        = '0;
      parser.half      = 1'b0;
      parser.budgeted  = 1'b0;
   endfunction

   // Advances the parser by one byte; returns 1 when the byte yields a token.
   function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                     input logic [1:0] kind, input logic [15:0] size,
                                     output rsp_type t);
      token_type   tok;
      logic [15:0] val;
      logic        word;
      logic        fin;
      bit          have;
      bit          pts_done;
      tok = TK_COUNT;
      val = '0;
      word = 1'b0;
      fin = 1'b0;
      have = 1'b0;
      pts_done = 1'b0;
      t = '{token: TK_ERROR, value: {8'd0, b}, value_is_word: 1'b0, section_end: 1'b1};
      if (start) begin
         parser_to_idle();
         if (kind == KIND_INVALID) return 1'b1;
         parser.budgeted = (kind != KIND_SHARED);
         parser.budget = parser.budgeted ? {1'b0, size} : 17'd0;
         parser.ph = (kind == KIND_PLAIN) ? PH_DCTRL : PH_COUNT;
      end else if (parser.ph == PH_IDLE) begin
         return 1'b0;
      end
      if (parser.budgeted) begin
         if (parser.budget == 0) begin
            parser_to_idle();
            return 1'b1;
         end
         parser.budget = parser.budget - 17'd1;
      end
      case (parser.ph)
         PH_COUNT: begin
            if ((b & MASK_TOP_BIT) != 0) begin
               parser.hi = b & MASK_LOW7;
               parser.ph = PH_COUNT2;
            end else begin
               tok = TK_COUNT;
               val = {8'd0, b};
               have = 1'b1;
               parser.pts_left = {7'd0, b};
               if (b == 0) pts_done = 1'b1;
               else parser.ph = PH_PRUN;
            end
         end
         PH_COUNT2: begin
            val = {parser.hi, b};
            tok = TK_COUNT;
            word = 1'b1;
            have = 1'b1;
            parser.pts_left = val[14:0];
            parser.hi = '0;
            if (parser.pts_left == 0) pts_done = 1'b1;
            else parser.ph = PH_PRUN;
         end
         PH_PRUN: begin
            tok = TK_PRUN;
            val = {8'd0, b};
            have = 1'b1;
            parser.run_left = b[6:0];
            parser.run_words = b[7];
            parser.half = 1'b0;
            parser.ph = PH_PVAL;
         end
         PH_PVAL, PH_DVAL: begin
            if (parser.run_words && !parser.half) begin
               parser.hi = b;
               parser.half = 1'b1;
            end else begin
               if (parser.run_words) begin
                  val = {parser.hi, b};
                  word = 1'b1;
                  parser.half = 1'b0;
                  parser.hi = '0;
               end else begin
                  val = {8'd0, b};
               end
               have = 1'b1;
               if (parser.ph == PH_PVAL) begin
                  tok = TK_POINT;
                  parser.pts_left = parser.pts_left - 15'd1;
                  if (parser.pts_left == 0) pts_done = 1'b1;
                  else if (parser.run_left == 0) parser.ph = PH_PRUN;
                  else parser.run_left = parser.run_left - 7'd1;
               end else begin
                  tok = TK_DELTA;
                  if (parser.run_left == 0) parser.ph = PH_DCTRL;
                  else parser.run_left = parser.run_left - 7'd1;
               end
            end
         end
         PH_DCTRL: begin
            have = 1'b1;
            if (b[7]) begin
               tok = TK_ZERO;
               val = {10'd0, b[5:0]} + 16'd1;
            end else begin
               tok = TK_DCTRL;
               val = {8'd0, b};
               parser.run_left = {1'b0, b[5:0]};
               parser.run_words = b[6];
               parser.half = 1'b0;
               parser.ph = PH_DVAL;
            end
         end
         default: begin
            parser_to_idle();
            return 1'b0;
         end
      endcase
      if (pts_done) begin
         parser.run_left = '0;
         parser.run_words = 1'b0;
         parser.half = 1'b0;
         if (parser.budgeted) begin
            parser.ph = PH_DCTRL;
         end else begin
            fin = 1'b1;
            parser_to_idle();
         end
      end
      // budget used up: clean end at a run boundary, otherwise an overrun
      if (parser.budgeted && parser.ph != PH_IDLE && parser.budget == 0) begin
         if (parser.ph == PH_DCTRL) begin
            fin = 1'b1;
         end else begin
            tok = TK_ERROR;
            val = {8'd0, b};
            word = 1'b0;
            fin = 1'b1;
            have = 1'b1;
         end
         parser_to_idle();
      end
      t = '{token: tok, value: val, value_is_word: word, section_end: fin};
      return have;
   endfunction

   function automatic void queue_byte(input logic [7:0] b, input logic start,
                                      input logic [1:0] kind, input logic [15:0] size);
      req_type r;
      r.data_byte = b;
      r.section_start = start;
      r.section_kind = kind;
      r.section_size = size;
      byte_feed.push_back(r);
   endfunction

   function automatic void add_points();
      int count;
      int left;
      int len;
      int n;
      bit wide;
      count = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 12);
      if (count > 127 || $urandom_range(0, 3) == 0) begin
         sec_bytes.push_back({1'b1, count[14:8]});
         sec_bytes.push_back(count[7:0]);
      end else begin
         sec_bytes.push_back(count[7:0]);
      end
      left = count;
      while (left > 0) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
         wide = 1'($urandom_range(0, 1));
         sec_bytes.push_back({wide, 7'(len - 1)});
         n = (len < left) ? len : left;
         repeat (n) begin
            sec_bytes.push_back(8'($urandom_range(0, 255)));
            if (wide) sec_bytes.push_back(8'($urandom_range(0, 255)));
         end
         left -= n;
      end
   endfunction

   function automatic void add_deltas();
      int len;
      int sel;
      repeat ($urandom_range(0, 5)) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
         sel = $urandom_range(0, 2);
         if (sel == 0) begin
            // zero run, word flag set at random: the zero flag must win
            sec_bytes.push_back({1'b1, 1'($urandom_range(0, 1)), 6'(len - 1)});
         end else begin
            sec_bytes.push_back({1'b0, 1'(sel == 2), 6'(len - 1)});
            repeat (len * sel) sec_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   // Builds one section; cut drops its tail so the next start abandons it.
   function automatic void build_section(input logic [1:0] kind, input bit cut);
      int n;
      int m;
      int keep;
      logic [15:0] size;
      sec_bytes.delete();
      if (kind != KIND_PLAIN) add_points();
      if (kind != KIND_SHARED) add_deltas();
      if (sec_bytes.size() == 0) sec_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
      n = sec_bytes.size();
      m = $urandom_range(0, 9);
      if (kind == KIND_SHARED) size = 16'($urandom_range(0, 65535));
      else if (m < 7) size = 16'(n);
      else if (m < 9) size = 16'(n - $urandom_range(1, (n < 3) ? n : 3));
      else size = 16'($urandom_range(n, 65535));
      keep = n;
      if (cut && n > 1) keep = $urandom_range(1, n - 1);
      for (int i = 0; i < keep; i++) begin
         if (i == 0) queue_byte(sec_bytes[i], 1'b1, kind, size);
         else queue_byte(sec_bytes[i], 1'b0, 2'($urandom_range(0, 3)),
                         16'($urandom_range(0, 65535)));
      end
      sections_built++;
   endfunction

   function automatic void add_noise();
      repeat ($urandom_range(1, 8)) begin
         queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                    2'($urandom_range(0, 3)),
                    $urandom_range(0, 1) ? 16'($urandom_range(0, 6))
                                         : 16'($urandom_range(0, 65535)));
      end
   endfunction

   function automatic void load_directed();
      // idle byte, ignored
      queue_byte(8'h55, 1'b0, KIND_SHARED, 16'd0);
      // bad kind
      queue_byte(8'hFF, 1'b1, KIND_INVALID, 16'hFFFF);
      // zero count as a byte, then as a word
      queue_byte(8'h00, 1'b1, KIND_SHARED, 16'd0);
      queue_byte(8'h80, 1'b1, KIND_SHARED, 16'd0);
      queue_byte(8'h00, 1'b0, KIND_SHARED, 16'd0);
      // largest word count, abandoned by the next start
      queue_byte(8'hFF, 1'b1, KIND_SHARED, 16'd0);
      queue_byte(8'hFF, 1'b0, KIND_SHARED, 16'd0);
      // word count 1, one word point of all ones
      queue_byte(8'h80, 1'b1, KIND_SHARED, 16'd0);
      queue_byte(8'h01, 1'b0, KIND_SHARED, 16'd0);
      queue_byte(8'h80, 1'b0, KIND_SHARED, 16'd0);
      queue_byte(8'hFF, 1'b0, KIND_SHARED, 16'd0);
      queue_byte(8'hFF, 1'b0, KIND_SHARED, 16'd0);
      // empty budget
      queue_byte(8'h00, 1'b1, KIND_PLAIN, 16'd0);
      // zero runs, both flags and the longest, exact end
      queue_byte(8'hC0, 1'b1, KIND_PLAIN, 16'd2);
      queue_byte(8'hBF, 1'b0, KIND_PLAIN, 16'd0);
      // overrun in the first half of a word delta
      queue_byte(8'h40, 1'b1, KIND_PLAIN, 16'd2);
      queue_byte(8'h12, 1'b0, KIND_PLAIN, 16'd0);
      // private points ending the budget, empty deltas
      queue_byte(8'h00, 1'b1, KIND_PRIVATE, 16'd1);
      // long run cut by count, then a restart mid-section
      queue_byte(8'h03, 1'b1, KIND_PRIVATE, 16'd100);
      queue_byte(8'h7F, 1'b0, KIND_PRIVATE, 16'd0);
      queue_byte(8'h10, 1'b0, KIND_PRIVATE, 16'd0);
      queue_byte(8'h01, 1'b1, KIND_SHARED, 16'd0);
      queue_byte(8'h00, 1'b0, KIND_SHARED, 16'd0);
      queue_byte(8'h00, 1'b0, KIND_SHARED, 16'd0);
   endfunction

   initial begin
      forever #4 clock = ~clock;
   end

   // request driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (byte_feed.size() > 0) begin
            next_req = byte_feed.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_req.data_byte;
            req_section_start <= next_req.section_start;
            req_section_kind <= next_req.section_kind;
            req_section_size <= next_req.section_size;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall pattern, with long hold-offs to back up the input side
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cyc++;
         if (hold_left == 0 && holds_done < 2 && reqs_taken >= 300 + 600 * holds_done) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 200);
            stall_mode = $urandom_range(0, 3);
         end else begin
            seg_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               2: rsp_stall <= ($urandom_range(0, 9) != 0);
               default: rsp_stall <= (cyc % 4) != 0;
            endcase
         end
      end
   end

   // monitor: predict on each taken request, check each taken token
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            tokens_taken++;
            if (tokens_due.size() == 0) begin
               $error("unexpected token %0d value %0h", rsp_token, rsp_value);
               fail_count++;
            end else begin
               want = tokens_due.pop_front();
               if (rsp_token != want.token) begin
                  $error("token: expected %0d, got %0d", want.token, rsp_token);
                  fail_count++;
               end
               if (rsp_value != want.value) begin
                  $error("value: expected %0h, got %0h", want.value, rsp_value);
                  fail_count++;
               end
               if (rsp_value_is_word != want.value_is_word) begin
                  $error("value_is_word: expected %0b, got %0b", want.value_is_word,
                         rsp_value_is_word);
                  fail_count++;
               end
               if (rsp_section_end != want.section_end) begin
                  $error("section_end: expected %0b, got %0b", want.section_end,
                         rsp_section_end);
                  fail_count++;
               end
               tok_hits[want.token]++;
            end
         end
         if (req_valid && !req_stall) begin
            reqs_taken++;
            if (parse_byte(req_data_byte, req_section_start, req_section_kind,
                           req_section_size, got))
               tokens_due.push_back(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $error("no request or token moved for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin
      int pick;
      parser_to_idle();
      load_directed();
      while (byte_feed.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) build_section(KIND_SHARED, 1'b0);
         else if (pick < 55) build_section(KIND_PLAIN, 1'b0);
         else if (pick < 80) build_section(KIND_PRIVATE, 1'b0);
         else if (pick < 90) add_noise();
         else build_section(2'($urandom_range(0, 2)), 1'b1);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (byte_feed.size() != 0 || req_valid) @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Ran %0d requests over %0d generated sections, %0d tokens checked.",
               reqs_taken, sections_built, tokens_taken);
      $display({"Tokens by kind: count %0d, point run %0d, point %0d, delta ctrl %0d,",
                " delta %0d, zero run %0d, error %0d"},
               tok_hits[TK_COUNT], tok_hits[TK_PRUN], tok_hits[TK_POINT], tok_hits[TK_DCTRL],
               tok_hits[TK_DELTA], tok_hits[TK_ZERO], tok_hits[TK_ERROR]);
      if (fail_count == 0 && tokens_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
